>>> hdl/edt_pkg.sv
// ----------------------------------------------------------------------------
// Distance transform package
// Shared constants, operation codes and the command and status records that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package edt_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0]     CFG_RESET  = 9'd256;

    localparam int PIX_W  = 8;
    localparam int DIST_W = 22;
    localparam int STS_W  = 2;
    localparam int SQD_W  = 27;
    localparam int BND_W  = 40;
    localparam int FRAC_W = 8;
    localparam int RAD_W  = 2 * DIST_W;

    localparam logic [SQD_W-1:0] FAR_SEED = 27'd100000000;
    localparam logic signed [BND_W-1:0] NEG_INF = {1'b1, {(BND_W-1){1'b0}}};
    localparam logic signed [BND_W-1:0] POS_INF = {1'b0, {(BND_W-1){1'b1}}};

    localparam logic [STS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STS_W-1:0] ST_MISMATCH = 2'd1;
    localparam logic [STS_W-1:0] ST_NOFRAME  = 2'd2;

    typedef enum logic [4:0] {
        OP_IDLE, OP_CHECK, OP_RD_MEM, OP_SQRT, OP_RESP,
        OP_LINE_START, OP_COPY_RD, OP_COPY_WR, OP_ENV_INIT, OP_ENV_INIT2,
        OP_E_Q, OP_E_V, OP_E_K, OP_E_F, OP_E_N, OP_E_DIV, OP_E_CMP, OP_E_TOP,
        OP_F_B, OP_F_C, OP_F_V, OP_F_S, OP_LINE_END
    } t_op;

    typedef struct packed {
        t_op  op;
        logic take;
    } t_cmd;

    typedef struct packed {
        logic is_load;
        logic fend;
        logic ready;
        logic count_ok;
        logic copy_last;
        logic len_one;
        logic div_done;
        logic pop;
        logic q_last;
        logic adv;
        logic line_last;
        logic pass_row;
        logic sqrt_done;
    } t_sts;

endpackage

`default_nettype wire

>>> hdl/euclidean_distance_transform.sv
// ----------------------------------------------------------------------------
// Exact Euclidean distance transform
// Loads a binary image, runs the separable lower-envelope transform and
// returns square-rooted distances in raster order.
// ----------------------------------------------------------------------------
// One request is taken at a time and answered before the next is accepted. A
// load request without frame end gives no result. A read request first reads
// the image store and then runs the bit-serial square root unit, whose result
// is the distance it returns. The load request that ends a complete frame
// triggers the transform, and its result appears only when the transform is
// done. The transform works one line at a time, first over every column and
// then over every row. For each line it copies the line out of the image
// store, evaluates the parabola intersections with the shared serial divider
// (its dividend is 37 bits wide at the default size), and then walks the
// envelope and writes the results back. Fewer than 2n intersections are
// evaluated for a line of n pixels. A mismatched pixel count is reported with
// status 1, a read without a finished frame with status 2. Configuration
// writes drop any loaded or finished frame and must only be made while the
// block is idle.
`timescale 1ns / 1ps
`default_nettype none

module euclidean_distance_transform import edt_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Request channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_cmd,
    input  wire logic [PIX_W-1:0]     i_pixel,
    input  wire logic                 i_frame_end,
    // Result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [DIST_W-1:0]         o_distance,
    output logic                      o_last,
    output logic [STS_W-1:0]          o_status,
    // Configuration port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // The controller decides the sequence; the datapath owns all storage.
    edt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    edt_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_ctl   (cmd),
        .i_cmd       (i_cmd),
        .i_pixel     (i_pixel),
        .i_frame_end (i_frame_end),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_sts       (sts),
        .o_distance  (o_distance),
        .o_last      (o_last),
        .o_status    (o_status)
    );

    // A pending result always blocks new requests.
    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("request channel open while a result is pending");

    // Once a result is taken, the block is ready for the next request.
    a_free_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> !o_in_stall)
        else $error("block not idle after result delivery");

    // The final distance of a frame only comes from a good frame.
    a_last_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_status == ST_OK))
        else $error("last flag on an error result");

    // Error results carry no distance.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_NOFRAME || o_status == ST_MISMATCH))
            |-> (o_distance == '0))
        else $error("error result with nonzero distance");

endmodule

`default_nettype wire

>>> hdl/edt_ctrl.sv
// ----------------------------------------------------------------------------
// Distance transform controller
// Sequences loads, reads and the two-pass envelope transform.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edt_ctrl import edt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_in_stall,
    output logic      o_out_valid
);

    typedef enum logic [22:0] {
        S_IDLE       = 23'h000001,
        S_CHECK      = 23'h000002,
        S_RD_MEM     = 23'h000004,
        S_SQRT       = 23'h000008,
        S_RESP       = 23'h000010,
        S_LINE_START = 23'h000020,
        S_COPY_RD    = 23'h000040,
        S_COPY_WR    = 23'h000080,
        S_ENV_INIT   = 23'h000100,
        S_ENV_INIT2  = 23'h000200,
        S_E_Q        = 23'h000400,
        S_E_V        = 23'h000800,
        S_E_K        = 23'h001000,
        S_E_F        = 23'h002000,
        S_E_N        = 23'h004000,
        S_E_DIV      = 23'h008000,
        S_E_CMP      = 23'h010000,
        S_E_TOP      = 23'h020000,
        S_F_B        = 23'h040000,
        S_F_C        = 23'h080000,
        S_F_V        = 23'h100000,
        S_F_S        = 23'h200000,
        S_LINE_END   = 23'h400000
    } t_state;

    t_state r_state, n_state;
    logic   take;

    assign take        = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_RESP);

    always_comb begin
        n_state    = r_state;
        o_cmd.take = take;
        o_cmd.op   = OP_IDLE;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.op = OP_IDLE;
                if (take) begin
                    if (i_sts.is_load) begin
                        if (i_sts.fend) n_state = S_CHECK;
                    end else begin
                        n_state = i_sts.ready ? S_RD_MEM : S_RESP;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.op = OP_CHECK;
                n_state  = i_sts.count_ok ? S_LINE_START : S_RESP;
            end
            S_RD_MEM: begin
                o_cmd.op = OP_RD_MEM;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (i_sts.sqrt_done) n_state = S_RESP;
            end
            S_RESP: begin
                o_cmd.op = OP_RESP;
                if (!i_out_stall) n_state = S_IDLE;
            end
            S_LINE_START: begin
                o_cmd.op = OP_LINE_START;
                n_state  = S_COPY_RD;
            end
            S_COPY_RD: begin
                o_cmd.op = OP_COPY_RD;
                n_state  = S_COPY_WR;
            end
            S_COPY_WR: begin
                o_cmd.op = OP_COPY_WR;
                n_state  = i_sts.copy_last ? S_ENV_INIT : S_COPY_RD;
            end
            S_ENV_INIT: begin
                o_cmd.op = OP_ENV_INIT;
                n_state  = S_ENV_INIT2;
            end
            S_ENV_INIT2: begin
                o_cmd.op = OP_ENV_INIT2;
                n_state  = i_sts.len_one ? S_F_B : S_E_Q;
            end
            S_E_Q: begin
                o_cmd.op = OP_E_Q;
                n_state  = S_E_V;
            end
            S_E_V: begin
                o_cmd.op = OP_E_V;
                n_state  = S_E_F;
            end
            S_E_K: begin
                o_cmd.op = OP_E_K;
                n_state  = S_E_F;
            end
            S_E_F: begin
                o_cmd.op = OP_E_F;
                n_state  = S_E_N;
            end
            S_E_N: begin
                o_cmd.op = OP_E_N;
                n_state  = S_E_DIV;
            end
            S_E_DIV: begin
                o_cmd.op = OP_E_DIV;
                if (i_sts.div_done) n_state = S_E_CMP;
            end
            S_E_CMP: begin
                o_cmd.op = OP_E_CMP;
                n_state  = i_sts.pop ? S_E_K : S_E_TOP;
            end
            S_E_TOP: begin
                o_cmd.op = OP_E_TOP;
                n_state  = i_sts.q_last ? S_F_B : S_E_Q;
            end
            S_F_B: begin
                o_cmd.op = OP_F_B;
                n_state  = S_F_C;
            end
            S_F_C: begin
                o_cmd.op = OP_F_C;
                n_state  = i_sts.adv ? S_F_B : S_F_V;
            end
            S_F_V: begin
                o_cmd.op = OP_F_V;
                n_state  = S_F_S;
            end
            S_F_S: begin
                o_cmd.op = OP_F_S;
                n_state  = i_sts.q_last ? S_LINE_END : S_F_B;
            end
            S_LINE_END: begin
                o_cmd.op = OP_LINE_END;
                n_state  = (i_sts.line_last && i_sts.pass_row) ? S_RESP : S_LINE_START;
            end
            default: begin
                o_cmd.op = OP_IDLE;
                n_state  = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> hdl/edt_dp.sv
// ----------------------------------------------------------------------------
// Distance transform datapath
// Image store, line scratch memories, boundary divider and square root unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edt_dp import edt_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd_ctl,
    input  wire logic                 i_cmd,
    input  wire logic [PIX_W-1:0]     i_pixel,
    input  wire logic                 i_frame_end,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output t_sts                      o_sts,
    output logic [DIST_W-1:0]         o_distance,
    output logic                      o_last,
    output logic [STS_W-1:0]          o_status
);

    localparam int LINE   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CAP    = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(CAP);
    localparam int CNT_W  = $clog2(CAP + 2);
    localparam int CW     = $clog2(LINE + 1);
    localparam int IW     = $clog2(LINE);
    localparam int DW     = ((SQD_W > 2 * IW) ? SQD_W : 2 * IW) + 1;
    localparam int NW     = DW + 1;
    localparam int AW     = NW + FRAC_W;
    localparam int RW     = IW + 2;
    localparam int DCW    = $clog2(AW + 1);
    localparam int SCW    = $clog2(DIST_W + 1);
    localparam int SRW    = DIST_W + 2;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAP);

    // Configuration and frame bookkeeping
    logic [CFG_W-1:0]  r_cfg_w, r_cfg_h;
    logic [CW-1:0]     eff_w, eff_h, len, nlines;
    logic [CNT_W-1:0]  r_npix, r_load_cnt;
    logic [ADDR_W-1:0] r_rp, stride;
    logic              r_ready;

    // Transform sequencing
    logic              r_pass;
    logic [CW-1:0]     r_line, r_i, r_k, k_inc;
    logic [ADDR_W-1:0] r_base, r_addr;
    logic [SQD_W-1:0]  r_fq;
    logic [IW-1:0]     r_v;
    logic signed [BND_W-1:0] r_bk;

    // Divider
    logic [AW-1:0]  r_dq;
    logic [RW-1:0]  r_rem, div_t, div_rem_n;
    logic [IW:0]    r_b;
    logic           r_neg, div_ge;
    logic [DCW-1:0] r_dcnt;

    // Square root
    logic [RAD_W-1:0]  r_rad;
    logic [DIST_W-1:0] r_root, root_n;
    logic [SRW-1:0]    r_srem, sq_t, sq_trial, srem_n;
    logic [SCW-1:0]    r_scnt;
    logic              sq_ge;

    // Result registers
    logic [DIST_W-1:0] r_o_dist;
    logic              r_o_last;
    logic [STS_W-1:0]  r_o_status;

    // Memories
    logic [SQD_W-1:0] m_store [CAP];
    logic [SQD_W-1:0] m_src [LINE];
    logic [IW-1:0]    m_vtx [LINE];
    logic signed [BND_W-1:0] m_bnd [LINE + 1];

    logic              store_we, src_we, vtx_we, bnd_we;
    logic [ADDR_W-1:0] store_wa, store_ra;
    logic [SQD_W-1:0]  store_wd, r_store_rd, src_wd, r_src_rd;
    logic [IW-1:0]     src_wa, src_ra, vtx_wa, vtx_ra, vtx_wd, r_vtx_rd;
    logic [CW-1:0]     bnd_wa, bnd_ra;
    logic signed [BND_W-1:0] bnd_wd, r_bnd_rd;

    // Arithmetic
    logic [2*IW-1:0]   q2, v2, dq2;
    logic [DW-1:0]     lhs, rhs;
    logic signed [NW-1:0] num;
    logic [NW-1:0]     num_abs;
    logic [AW-1:0]     a_mag;
    logic signed [BND_W-1:0] q_s, s_raw, s_val, q256;
    logic [IW-1:0]     qi, dq;
    logic [SQD_W-1:0]  fill_val;
    logic              take_load, take_read;

    assign eff_w = (r_cfg_w == '0) ? CW'(1) :
                   (int'(r_cfg_w) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(r_cfg_w);
    assign eff_h = (r_cfg_h == '0) ? CW'(1) :
                   (int'(r_cfg_h) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(r_cfg_h);
    assign len    = r_pass ? eff_w : eff_h;
    assign nlines = r_pass ? eff_h : eff_w;
    assign stride = r_pass ? ADDR_W'(1) : ADDR_W'(eff_w);
    assign k_inc  = r_k + 1'b1;
    assign qi     = r_i[IW-1:0];

    assign take_load = i_cmd_ctl.take && !i_cmd;
    assign take_read = i_cmd_ctl.take && i_cmd;

    // Parabola intersection numerator and magnitude of the scaled dividend.
    assign q2      = qi * qi;
    assign v2      = r_v * r_v;
    assign lhs     = DW'(r_fq) + DW'(q2);
    assign rhs     = DW'(r_src_rd) + DW'(v2);
    assign num     = $signed({1'b0, lhs}) - $signed({1'b0, rhs});
    assign num_abs = num[NW-1] ? NW'(-num) : NW'(num);
    assign a_mag   = {num_abs, {FRAC_W{1'b0}}};

    assign div_t     = {r_rem[RW-2:0], r_dq[AW-1]};
    assign div_ge    = div_t >= {1'b0, r_b};
    assign div_rem_n = div_ge ? div_t - {1'b0, r_b} : div_t;

    // Floor division: a negative quotient with a remainder rounds down.
    always_comb begin
        q_s   = $signed(BND_W'(r_dq));
        s_raw = r_neg ? (-q_s - $signed(BND_W'(r_rem != '0))) : q_s;
        if (s_raw <= NEG_INF) begin
            s_val = NEG_INF + 1;
        end else if (s_raw >= POS_INF) begin
            s_val = POS_INF - 1;
        end else begin
            s_val = s_raw;
        end
    end

    assign q256 = $signed(BND_W'({r_i, {FRAC_W{1'b0}}}));

    assign dq       = (qi > r_v) ? qi - r_v : r_v - qi;
    assign dq2      = dq * dq;
    assign fill_val = SQD_W'(dq2) + r_src_rd;

    assign sq_t     = {r_srem[SRW-3:0], r_rad[RAD_W-1 -: 2]};
    assign sq_trial = {r_root, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;
    assign srem_n   = sq_ge ? sq_t - sq_trial : sq_t;
    assign root_n   = {r_root[DIST_W-2:0], sq_ge};

    always_comb begin
        o_sts.is_load   = !i_cmd;
        o_sts.fend      = i_frame_end;
        o_sts.ready     = r_ready;
        o_sts.count_ok  = (r_load_cnt == r_npix);
        o_sts.copy_last = (r_i == len - 1'b1);
        o_sts.len_one   = (len == CW'(1));
        o_sts.div_done  = (r_dcnt == DCW'(1));
        o_sts.pop       = (r_k != '0) && (s_val <= r_bk);
        o_sts.q_last    = (r_i == len - 1'b1);
        o_sts.adv       = (k_inc < len) && (r_bnd_rd < q256);
        o_sts.line_last = (r_line == nlines - 1'b1);
        o_sts.pass_row  = r_pass;
        o_sts.sqrt_done = (r_scnt == SCW'(1));
    end

    // Memory port steering
    always_comb begin
        store_we = 1'b0;
        store_wa = r_addr;
        store_wd = fill_val;
        store_ra = r_rp;
        src_we   = 1'b0;
        src_wa   = qi;
        src_wd   = r_store_rd;
        src_ra   = qi;
        vtx_we   = 1'b0;
        vtx_wa   = k_inc[IW-1:0];
        vtx_wd   = qi;
        vtx_ra   = r_k[IW-1:0];
        bnd_we   = 1'b0;
        bnd_wa   = k_inc;
        bnd_wd   = POS_INF;
        bnd_ra   = r_k;
        case (i_cmd_ctl.op)
            OP_IDLE: begin
                if (take_load && (r_load_cnt < CAP_C)) begin
                    store_we = 1'b1;
                    store_wa = r_load_cnt[ADDR_W-1:0];
                    store_wd = (i_pixel == '0) ? '0 : FAR_SEED;
                end
            end
            OP_COPY_RD: store_ra = r_addr;
            OP_COPY_WR: src_we = 1'b1;
            OP_ENV_INIT: begin
                vtx_we = 1'b1;
                vtx_wa = '0;
                vtx_wd = '0;
                bnd_we = 1'b1;
                bnd_wa = '0;
                bnd_wd = NEG_INF;
            end
            OP_ENV_INIT2: begin
                bnd_we = 1'b1;
                bnd_wa = CW'(1);
            end
            OP_E_F: src_ra = r_vtx_rd;
            OP_E_CMP: begin
                if (!o_sts.pop) begin
                    vtx_we = 1'b1;
                    bnd_we = 1'b1;
                    bnd_wd = s_val;
                end
            end
            OP_E_TOP: bnd_we = 1'b1;
            OP_F_B:   bnd_ra = k_inc;
            OP_F_V:   src_ra = r_vtx_rd;
            OP_F_S:   store_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (store_we) m_store[store_wa] <= store_wd;
        r_store_rd <= m_store[store_ra];
    end

    always_ff @(posedge i_clk) begin
        if (src_we) m_src[src_wa] <= src_wd;
        r_src_rd <= m_src[src_ra];
    end

    always_ff @(posedge i_clk) begin
        if (vtx_we) m_vtx[vtx_wa] <= vtx_wd;
        r_vtx_rd <= m_vtx[vtx_ra];
    end

    always_ff @(posedge i_clk) begin
        if (bnd_we) m_bnd[bnd_wa] <= bnd_wd;
        r_bnd_rd <= m_bnd[bnd_ra];
    end

    // Frame bookkeeping and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= CFG_RESET;
            r_cfg_h    <= CFG_RESET;
            r_load_cnt <= '0;
            r_rp       <= '0;
            r_ready    <= 1'b0;
        end else begin
            case (i_cmd_ctl.op)
                OP_IDLE: begin
                    if (take_load) begin
                        r_ready <= 1'b0;
                        if (r_ready) r_rp <= '0;
                        if (r_load_cnt <= CAP_C) r_load_cnt <= r_load_cnt + 1'b1;
                    end
                end
                OP_CHECK: r_load_cnt <= '0;
                OP_RD_MEM: begin
                    if (CNT_W'(r_rp) == r_npix - 1'b1) begin
                        r_rp <= '0;
                    end else begin
                        r_rp <= r_rp + 1'b1;
                    end
                end
                OP_LINE_END: begin
                    if (o_sts.line_last && r_pass) begin
                        r_ready <= 1'b1;
                        r_rp    <= '0;
                    end
                end
                default: ;
            endcase
            if (i_cfg_we && (i_cfg_idx == REG_WIDTH || i_cfg_idx == REG_HEIGHT)) begin
                if (i_cfg_idx == REG_WIDTH) r_cfg_w <= i_cfg_data;
                else                        r_cfg_h <= i_cfg_data;
                r_load_cnt <= '0;
                r_rp       <= '0;
                r_ready    <= 1'b0;
            end
        end
    end

    // Working registers of the transform, divider and square root
    always_ff @(posedge i_clk) begin
        r_npix <= CNT_W'(eff_w) * CNT_W'(eff_h);
        case (i_cmd_ctl.op)
            OP_IDLE: begin
                if (take_read && !r_ready) begin
                    r_o_dist   <= '0;
                    r_o_last   <= 1'b0;
                    r_o_status <= ST_NOFRAME;
                end
            end
            OP_CHECK: begin
                r_o_dist   <= '0;
                r_o_last   <= 1'b0;
                r_o_status <= ST_MISMATCH;
                r_pass     <= 1'b0;
                r_line     <= '0;
                r_base     <= '0;
            end
            OP_RD_MEM: begin
                r_rad      <= RAD_W'({r_store_rd, 16'b0});
                r_root     <= '0;
                r_srem     <= '0;
                r_scnt     <= SCW'(DIST_W);
                r_o_last   <= (CNT_W'(r_rp) == r_npix - 1'b1);
                r_o_status <= ST_OK;
            end
            OP_SQRT: begin
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_srem <= srem_n;
                r_root <= root_n;
                r_scnt <= r_scnt - 1'b1;
                if (o_sts.sqrt_done) r_o_dist <= root_n;
            end
            OP_LINE_START: begin
                r_i    <= '0;
                r_addr <= r_base;
            end
            OP_COPY_WR: begin
                r_i    <= r_i + 1'b1;
                r_addr <= r_addr + stride;
            end
            OP_ENV_INIT2: begin
                r_k <= '0;
                if (o_sts.len_one) begin
                    r_i    <= '0;
                    r_addr <= r_base;
                end else begin
                    r_i <= CW'(1);
                end
            end
            OP_E_V: r_fq <= r_src_rd;
            OP_E_F: begin
                r_v  <= r_vtx_rd;
                r_bk <= r_bnd_rd;
            end
            OP_E_N: begin
                r_dq   <= a_mag;
                r_rem  <= '0;
                r_b    <= {qi - r_v, 1'b0};
                r_neg  <= num[NW-1];
                r_dcnt <= DCW'(AW);
            end
            OP_E_DIV: begin
                r_dq   <= {r_dq[AW-2:0], div_ge};
                r_rem  <= div_rem_n;
                r_dcnt <= r_dcnt - 1'b1;
            end
            OP_E_CMP: begin
                if (o_sts.pop) r_k <= r_k - 1'b1;
                else           r_k <= k_inc;
            end
            OP_E_TOP: begin
                if (o_sts.q_last) begin
                    r_i    <= '0;
                    r_k    <= '0;
                    r_addr <= r_base;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            OP_F_C: if (o_sts.adv) r_k <= k_inc;
            OP_F_V: r_v <= r_vtx_rd;
            OP_F_S: begin
                r_i    <= r_i + 1'b1;
                r_addr <= r_addr + stride;
            end
            OP_LINE_END: begin
                if (o_sts.line_last) begin
                    if (!r_pass) begin
                        r_pass <= 1'b1;
                        r_line <= '0;
                        r_base <= '0;
                    end else begin
                        r_o_dist   <= '0;
                        r_o_last   <= 1'b0;
                        r_o_status <= ST_OK;
                    end
                end else begin
                    r_line <= r_line + 1'b1;
                    r_base <= r_base + (r_pass ? ADDR_W'(eff_w) : ADDR_W'(1));
                end
            end
            default: ;
        endcase
    end

    assign o_distance = r_o_dist;
    assign o_last     = r_o_last;
    assign o_status   = r_o_status;

endmodule

`default_nettype wire
